/* src/slp_pkg.sv */
// Package for the show-file line parser.
// Holds character codes, value limits, result, verdict and phase codes, and the result bundle type.
// No dependencies.
package slp_pkg;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  // Largest channel value, and the saturation point of the leading number.
  localparam logic [19:0] SLOT_VALUE_MAX = 20'd255;
  localparam logic [19:0] HEAD_SAT_WIDE  = 20'd65536;
  localparam logic [16:0] HEAD_SAT       = 17'd65536;

  typedef enum logic [2:0] {
    RK_SLOT   = 3'd0,
    RK_FRAME  = 3'd1,
    RK_DELAY  = 3'd2,
    RK_FAILED = 3'd3,
    RK_EOF    = 3'd4
  } result_kind_e;

  // Verdict held while the rest of a line is skipped.
  typedef enum logic [1:0] {
    VD_NONE   = 2'd0,
    VD_FRAME  = 2'd1,
    VD_DELAY  = 2'd2,
    VD_FAILED = 2'd3
  } verdict_e;

  typedef enum logic [4:0] {
    PH_LINE_START = 5'b00001,
    PH_HEAD_NUM   = 5'b00010,
    PH_DATA_START = 5'b00100,
    PH_DATA_NUM   = 5'b01000,
    PH_SKIP       = 5'b10000
  } phase_e;

  // Up to three results caused by one input item, emitted in field order:
  // slot write, line verdict, end of file.
  typedef struct packed {
    logic         slot_v;
    logic [8:0]   slot_idx;
    logic [7:0]   slot_val;
    logic         verdict_v;
    result_kind_e verdict_kind;
    logic [15:0]  verdict_num;
    logic [9:0]   verdict_cnt;
    logic         eof_v;
  } slp_bundle_t;

endpackage

/* src/slp_if.sv */
// Stream interfaces of the show-file line parser: characters in, results out.
// Depends on nothing but the field widths of the block.
interface slp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface slp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [8:0] slot_index;
  logic [15:0] number;
  logic [9:0] slot_count;
  logic       last;

  modport source (output valid, output result_kind, output slot_index, output number,
                  output slot_count, output last, input ready);
  modport sink   (input valid, input result_kind, input slot_index, input number,
                  input slot_count, input last, output ready);
endinterface

/* src/slp_parse.sv */
// Line parsing state of the show-file line parser and the per-character update.
// Depends on slp_pkg for codes and the result bundle type.
module slp_parse import slp_pkg::*; #(
  parameter int MaxSlots = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        kind_i,
  input  logic [7:0]  char_code_i,
  output slp_bundle_t bundle_o
);

  localparam logic [9:0] SlotLimit = 10'(MaxSlots);

  phase_e      phase_q, phase_d;
  logic [16:0] acc_q, acc_d;
  logic [15:0] univ_q, univ_d;
  logic [9:0]  slots_q, slots_d;
  verdict_e    pend_q, pend_d;

  logic        digit;
  logic [3:0]  digit_val;
  logic [19:0] acc_x10;
  logic        slots_full;
  logic        line_end;
  verdict_e    verdict;

  always_comb begin
    digit     = char_code_i inside {[CH_ZERO:CH_NINE]};
    digit_val = digit ? 4'(char_code_i - CH_ZERO) : 4'd0;
    acc_x10   = ({3'b000, acc_q} << 3) + ({3'b000, acc_q} << 1) + {16'd0, digit_val};
    slots_full = slots_q >= SlotLimit;
    line_end  = kind_i || (char_code_i == CH_NEWLINE);
  end

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    univ_d   = univ_q;
    slots_d  = slots_q;
    pend_d   = pend_q;
    verdict  = VD_NONE;
    bundle_o = '0;
    bundle_o.verdict_kind = RK_FAILED;

    if (line_end) begin
      // Close the line: a value being read is written, then the verdict.
      case (phase_q)
        PH_LINE_START: begin
          if (!kind_i) begin
            verdict = VD_FAILED;
          end
        end
        PH_HEAD_NUM:   verdict = acc_q[16] ? VD_FAILED : VD_DELAY;
        PH_DATA_START: verdict = VD_FRAME;
        PH_DATA_NUM: begin
          if (slots_full) begin
            verdict = VD_FAILED;
          end else begin
            bundle_o.slot_v   = 1'b1;
            bundle_o.slot_idx = slots_q[8:0];
            bundle_o.slot_val = acc_q[7:0];
            verdict = VD_FRAME;
          end
        end
        default:       verdict = (pend_q == VD_NONE) ? VD_FAILED : pend_q;
      endcase

      bundle_o.verdict_v = verdict != VD_NONE;
      case (verdict)
        VD_FRAME: begin
          bundle_o.verdict_kind = RK_FRAME;
          bundle_o.verdict_num  = univ_q;
          bundle_o.verdict_cnt  = bundle_o.slot_v ? slots_q + 10'd1 : slots_q;
        end
        VD_DELAY: begin
          bundle_o.verdict_kind = RK_DELAY;
          bundle_o.verdict_num  = acc_q[15:0];
        end
        default: bundle_o.verdict_kind = RK_FAILED;
      endcase
      bundle_o.eof_v = kind_i;

      phase_d = PH_LINE_START;
      acc_d   = '0;
      univ_d  = '0;
      slots_d = '0;
      pend_d  = VD_NONE;
    end else begin
      case (phase_q)
        PH_LINE_START: begin
          if (digit) begin
            acc_d   = {13'd0, digit_val};
            phase_d = PH_HEAD_NUM;
          end else begin
            pend_d  = VD_FAILED;
            phase_d = PH_SKIP;
          end
        end
        PH_HEAD_NUM: begin
          if (digit) begin
            acc_d = (acc_x10 > HEAD_SAT_WIDE) ? HEAD_SAT : acc_x10[16:0];
          end else if (acc_q[16]) begin
            pend_d  = VD_FAILED;
            phase_d = PH_SKIP;
          end else if (char_code_i == CH_SPACE) begin
            univ_d  = acc_q[15:0];
            acc_d   = '0;
            slots_d = '0;
            phase_d = PH_DATA_START;
          end else begin
            pend_d  = VD_DELAY;
            phase_d = PH_SKIP;
          end
        end
        PH_DATA_START: begin
          if (digit) begin
            acc_d   = {13'd0, digit_val};
            phase_d = PH_DATA_NUM;
          end else begin
            pend_d  = VD_FRAME;
            phase_d = PH_SKIP;
          end
        end
        PH_DATA_NUM: begin
          if (digit) begin
            acc_d = acc_x10[16:0];
            if (acc_x10 > SLOT_VALUE_MAX) begin
              pend_d  = VD_FAILED;
              phase_d = PH_SKIP;
            end
          end else if (slots_full) begin
            pend_d  = VD_FAILED;
            phase_d = PH_SKIP;
          end else begin
            bundle_o.slot_v   = 1'b1;
            bundle_o.slot_idx = slots_q[8:0];
            bundle_o.slot_val = acc_q[7:0];
            slots_d = slots_q + 10'd1;
            acc_d   = '0;
            phase_d = PH_DATA_START;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE_START;
      acc_q   <= '0;
      univ_q  <= '0;
      slots_q <= '0;
      pend_q  <= VD_NONE;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      univ_q  <= univ_d;
      slots_q <= slots_d;
      pend_q  <= pend_d;
    end
  end

endmodule

/* src/show_line_parser.sv */
// Show-file line parser: one character (or end-of-file marker) per transaction.
// Results are registered and offered after the edge that accepts their input.
// One input per cycle while the receiver keeps up; an input causing n results
// holds the result register until all leave, one per cycle through one port.
// Reset (asynchronous, active low) returns the parser to line start, empty.
// Depends on slp_pkg, slp_if and slp_parse.
module show_line_parser import slp_pkg::*; #(
  parameter int MAX_SLOTS = 512
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  slp_in_if.sink    in_i,
  slp_out_if.source out_o
);

  // The parser updates its line state at the accepting edge and hands over
  // every result that the character causes as one bundle. The bundle register
  // then drains one result per transaction in the order slot write, verdict,
  // end of file. A new character is taken as soon as the bundle is empty, or
  // when its final result leaves in the same cycle, so the two sides never
  // wait on one another for the common one-result-or-none case.

  slp_bundle_t bundle_d;
  slp_bundle_t bundle_q;
  logic        in_accept;
  logic        out_accept;
  logic        one_left;

  assign in_accept  = in_i.valid && in_i.ready;
  assign out_accept = out_o.valid && out_o.ready;

  slp_parse #(
    .MaxSlots (MAX_SLOTS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .kind_i      (in_i.kind),
    .char_code_i (in_i.char_code),
    .bundle_o    (bundle_d)
  );

  assign one_left = $onehot({bundle_q.slot_v, bundle_q.verdict_v, bundle_q.eof_v});

  assign in_i.ready  = !out_o.valid || (one_left && out_o.ready);
  assign out_o.valid = bundle_q.slot_v || bundle_q.verdict_v || bundle_q.eof_v;

  // The earliest pending result in the bundle is the one on the port.
  always_comb begin
    out_o.result_kind = 3'(RK_EOF);
    out_o.slot_index  = '0;
    out_o.number      = '0;
    out_o.slot_count  = '0;
    out_o.last        = 1'b1;
    if (bundle_q.slot_v) begin
      out_o.result_kind = 3'(RK_SLOT);
      out_o.slot_index  = bundle_q.slot_idx;
      out_o.number      = {8'd0, bundle_q.slot_val};
      out_o.last        = !bundle_q.verdict_v && !bundle_q.eof_v;
    end else if (bundle_q.verdict_v) begin
      out_o.result_kind = 3'(bundle_q.verdict_kind);
      out_o.number      = bundle_q.verdict_num;
      out_o.slot_count  = bundle_q.verdict_cnt;
      out_o.last        = !bundle_q.eof_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bundle_q <= '0;
    end else if (in_accept) begin
      bundle_q <= bundle_d;
    end else if (out_accept) begin
      if (bundle_q.slot_v) begin
        bundle_q.slot_v <= 1'b0;
      end else if (bundle_q.verdict_v) begin
        bundle_q.verdict_v <= 1'b0;
      end else begin
        bundle_q.eof_v <= 1'b0;
      end
    end
  end

endmodule

/* tb/show_line_parser_checker.sv */
`timescale 1ns / 100ps
// Result checker for the show-file line parser testbench.
// Watches both streams, predicts every result from the accepted characters and
// compares them in order. Depends on slp_pkg and the interfaces in slp_if.
module show_line_parser_checker import slp_pkg::*; #(
  parameter int MAX_SLOTS = 512
) (
  input  logic clk_i,
  input  logic rst_ni,
  slp_in_if    in_mon,
  slp_out_if   out_mon,
  output int   mismatch_count_o,
  output int   outstanding_o
);

  typedef struct packed {
    result_kind_e kind;
    logic [8:0]   slot_index;
    logic [15:0]  number;
    logic [9:0]   slot_count;
    logic         last;
  } line_result_t;

  line_result_t expected_q[$];
  line_result_t oldest;

  // Parser state, kept apart from the block.
  phase_e       parse_phase;
  logic [16:0]  number_acc;
  logic [15:0]  universe_held;
  logic [9:0]   slots_done;
  verdict_e     skip_verdict;

  int results_this_item;
  int mismatches = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 40) begin
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic queue_result(input result_kind_e kind, input logic [8:0] idx,
                              input logic [15:0] num, input logic [9:0] cnt);
    line_result_t r;
    r.kind       = kind;
    r.slot_index = idx;
    r.number     = num;
    r.slot_count = cnt;
    r.last       = 1'b0;
    expected_q.push_back(r);
    results_this_item++;
  endtask

  task automatic clear_line();
    parse_phase   = PH_LINE_START;
    number_acc    = '0;
    universe_held = '0;
    slots_done    = '0;
    skip_verdict  = VD_NONE;
  endtask

  task automatic start_skip(input verdict_e v);
    skip_verdict = v;
    parse_phase  = PH_SKIP;
  endtask

  task automatic emit_verdict(input verdict_e v);
    case (v)
      VD_FRAME: queue_result(RK_FRAME, '0, universe_held, slots_done);
      VD_DELAY: queue_result(RK_DELAY, '0, number_acc[15:0], '0);
      default:  queue_result(RK_FAILED, '0, '0, '0);
    endcase
    clear_line();
  endtask

  // Ends the current line, at a newline or at the end of the file.
  task automatic close_line(input bit at_eof);
    case (parse_phase)
      PH_LINE_START: begin
        if (!at_eof) emit_verdict(VD_FAILED);
      end
      PH_HEAD_NUM: begin
        if (number_acc > 17'd65535) emit_verdict(VD_FAILED);
        else emit_verdict(VD_DELAY);
      end
      PH_DATA_START: emit_verdict(VD_FRAME);
      PH_DATA_NUM: begin
        if (slots_done >= MAX_SLOTS) begin
          emit_verdict(VD_FAILED);
        end else begin
          queue_result(RK_SLOT, slots_done[8:0], number_acc[15:0], '0);
          slots_done++;
          emit_verdict(VD_FRAME);
        end
      end
      default: begin
        if (skip_verdict == VD_NONE) emit_verdict(VD_FAILED);
        else emit_verdict(skip_verdict);
      end
    endcase
    clear_line();
  endtask

  task automatic predict_item(input logic is_eof, input logic [7:0] ch);
    logic        is_digit;
    logic [3:0]  digit;
    int unsigned grown;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    digit    = 4'(ch - CH_ZERO);
    results_this_item = 0;
    if (is_eof) begin
      close_line(1'b1);
      queue_result(RK_EOF, '0, '0, '0);
    end else if (ch == CH_NEWLINE) begin
      close_line(1'b0);
    end else begin
      case (parse_phase)
        PH_LINE_START: begin
          if (is_digit) begin
            number_acc  = 17'(digit);
            parse_phase = PH_HEAD_NUM;
          end else begin
            start_skip(VD_FAILED);
          end
        end
        PH_HEAD_NUM: begin
          if (is_digit) begin
            // Saturates one above the largest universe or delay.
            grown = int'(number_acc) * 10 + int'(digit);
            number_acc = (grown > 65536) ? HEAD_SAT : 17'(grown);
          end else if (number_acc > 17'd65535) begin
            start_skip(VD_FAILED);
          end else if (ch == CH_SPACE) begin
            universe_held = number_acc[15:0];
            number_acc    = '0;
            slots_done    = '0;
            parse_phase   = PH_DATA_START;
          end else begin
            start_skip(VD_DELAY);
          end
        end
        PH_DATA_START: begin
          if (is_digit) begin
            number_acc  = 17'(digit);
            parse_phase = PH_DATA_NUM;
          end else begin
            start_skip(VD_FRAME);
          end
        end
        PH_DATA_NUM: begin
          if (is_digit) begin
            number_acc = 17'(int'(number_acc) * 10 + int'(digit));
            if (number_acc > 17'd255) start_skip(VD_FAILED);
          end else if (slots_done >= MAX_SLOTS) begin
            start_skip(VD_FAILED);
          end else begin
            queue_result(RK_SLOT, slots_done[8:0], number_acc[15:0], '0);
            slots_done++;
            number_acc  = '0;
            parse_phase = PH_DATA_START;
          end
        end
        default: ;
      endcase
    end
    if (results_this_item > 0) expected_q[expected_q.size() - 1].last = 1'b1;
  endtask

  // Results are compared before the item of the same edge is predicted, since
  // no result can leave on the edge that accepts its cause.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unrequested result, kind", out_mon.result_kind, 0);
        end else begin
          oldest = expected_q.pop_front();
          if (out_mon.result_kind !== oldest.kind)
            report_mismatch("result_kind", out_mon.result_kind, oldest.kind);
          if (out_mon.slot_index !== oldest.slot_index)
            report_mismatch("slot_index", out_mon.slot_index, oldest.slot_index);
          if (out_mon.number !== oldest.number)
            report_mismatch("number", out_mon.number, oldest.number);
          if (out_mon.slot_count !== oldest.slot_count)
            report_mismatch("slot_count", out_mon.slot_count, oldest.slot_count);
          if (out_mon.last !== oldest.last)
            report_mismatch("last", out_mon.last, oldest.last);
        end
      end
      if (in_mon.valid && in_mon.ready) predict_item(in_mon.kind, in_mon.char_code);
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= expected_q.size();
  end

endmodule

/* tb/show_line_parser_tb.sv */
`timescale 1ns / 100ps
// Top of the show-file line parser testbench: clock, reset, stimulus and verdict.
// Depends on slp_pkg, slp_if, show_line_parser and show_line_parser_checker.
module show_line_parser_tb;
  import slp_pkg::*;

  localparam int         MAX_SLOTS   = 512;
  localparam int         CYCLE_LIMIT = 300000;
  localparam logic [7:0] CH_COMMA    = 8'd44;

  logic clk_i = 1'b0;
  logic rst_ni;

  slp_in_if  in_ch ();
  slp_out_if out_ch ();

  int          mismatch_count;
  int          outstanding;
  int          cycle_count = 0;
  int unsigned items_sent  = 0;

  // Idling controls. The receiver picks up a hold-off request in its own
  // process and counts the stretch itself.
  bit in_gaps_on    = 1'b1;
  bit out_stalls_on = 1'b1;
  int hold_off_req  = 0;

  always #2 clk_i = ~clk_i;

  show_line_parser #(.MAX_SLOTS(MAX_SLOTS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  show_line_parser_checker #(.MAX_SLOTS(MAX_SLOTS)) u_result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Any non-digit other than a newline closes a channel value; a comma is the
  // usual one.
  function automatic logic [7:0] pick_separator();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 6) return CH_COMMA;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_NEWLINE);
    return c;
  endfunction

  // Offers one transaction and holds it until the parser takes it. The valid
  // line is only lowered when a gap follows, so that back-to-back transactions
  // never see it dropped and raised within one time step.
  task automatic send_item(input logic is_eof, input logic [7:0] ch);
    int unsigned gap;
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= is_eof;
    in_ch.char_code <= ch;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_number(input int unsigned value);
    send_text($sformatf("%0d", value));
  endtask

  // Lets every outstanding result come out before anything else is offered.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // A frame line with a given number of channel values, all in range.
  task automatic send_slot_line(input int count, input bit trailing_sep);
    send_number($urandom_range(0, 65535));
    send_item(1'b0, CH_SPACE);
    for (int i = 0; i < count; i++) begin
      send_number($urandom_range(0, 255));
      if (i + 1 < count || trailing_sep) send_item(1'b0, CH_COMMA);
    end
    send_item(1'b0, CH_NEWLINE);
  endtask

  // Ends a random line, usually with a newline and now and then with the end
  // of the file, carrying an arbitrary byte that the parser must ignore.
  task automatic end_random_line();
    if ($urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom));
    else send_item(1'b0, CH_NEWLINE);
  endtask

  // Most random lines are well-formed frames with random content, since only
  // those reach the channel data; the rest are delay lines and plain noise.
  task automatic send_random_line();
    int unsigned pick;
    int unsigned value;
    int unsigned count;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 19))
        0:       value = 65535;
        1:       value = $urandom_range(65536, 99999);
        2:       value = $urandom_range(1000, 65535);
        default: value = $urandom_range(0, 600);
      endcase
      if ($urandom_range(0, 9) == 0) send_item(1'b0, CH_ZERO);
      send_number(value);
      send_item(1'b0, CH_SPACE);
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      for (int i = 0; i < count; i++) begin
        value = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999)
                                            : $urandom_range(0, 255);
        send_number(value);
        if (i + 1 < count || $urandom_range(0, 1) == 1) send_item(1'b0, pick_separator());
        // A second separator ends the channel data early.
        if ($urandom_range(0, 19) == 0) send_item(1'b0, pick_separator());
      end
    end else if (pick < 85) begin
      value = ($urandom_range(0, 9) == 0) ? $urandom_range(65536, 200000)
                                          : $urandom_range(0, 65535);
      send_number(value);
      if ($urandom_range(0, 2) != 0) begin
        do c = pick_separator(); while (c == CH_SPACE);
        send_item(1'b0, c);
        count = $urandom_range(0, 4);
        for (int i = 0; i < count; i++) begin
          do c = 8'($urandom); while (c == CH_NEWLINE);
          send_item(1'b0, c);
        end
      end
    end else begin
      count = $urandom_range(1, 8);
      for (int i = 0; i < count; i++) send_item(1'b0, 8'($urandom));
    end
    end_random_line();
  endtask

  // Receiver. It stalls at random while stalls are enabled, and takes one
  // long hold-off when asked, counting the cycles in this process.
  initial begin
    int unsigned stall;
    forever begin
      if (hold_off_req != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_req) @(posedge clk_i);
        hold_off_req = 0;
      end else begin
        stall = out_stalls_on ? pick_gap() : 0;
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // A run that stops making progress ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** show_line_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned first_item;
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= 1'b0;
    in_ch.char_code <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines: empty line, a line opening with byte zero, the largest
    // universe with the extreme channel values, a universe one too large, a
    // frame with no channel data, a channel value out of range after a good
    // one, two separators in a row, a delay, a saturated leading number, a
    // delay followed by text, a byte above 127 as a separator, and the end of
    // the file both in mid-value and at line start.
    send_text("\n");
    send_item(1'b0, 8'h00);
    send_text("\n");
    send_text("65535 255,0\n");
    send_text("65536 1\n");
    send_text("0 \n");
    send_text("12 1,256\n");
    send_text("3 1,,9\n");
    send_text("40\n");
    send_text("99999\n");
    send_text("250ms\n");
    send_text("1 4");
    send_item(1'b0, 8'hC8);
    send_text("5\n");
    send_text("5 7");
    send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'h00);
    wait_for_results();

    // The slot limit: a full frame, one value too many closed by the newline,
    // and one value too many closed by a separator. Idling is off here to keep
    // these long lines quick.
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    send_slot_line(MAX_SLOTS, 1'b0);
    send_slot_line(MAX_SLOTS + 1, 1'b0);
    send_slot_line(MAX_SLOTS + 1, 1'b1);
    wait_for_results();

    // Back-pressure: the receiver holds off for a long stretch while a busy
    // line keeps coming, so the parser fills up and refuses further input.
    hold_off_req = 300;
    send_slot_line(60, 1'b0);
    wait_for_results();

    // Random lines, with the idling pattern changed every few lines and an
    // occasional pause until the parser has drained.
    first_item = items_sent;
    while (items_sent - first_item < 250) begin
      if ($urandom_range(0, 3) == 0) begin
        in_gaps_on    = $urandom_range(0, 1);
        out_stalls_on = $urandom_range(0, 1);
      end
      send_random_line();
      if ($urandom_range(0, 19) == 0) wait_for_results();
    end
    send_item(1'b1, 8'($urandom));

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** show_line_parser: PASSED **");
    end else begin
      $display("** show_line_parser: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
src/slp_pkg.sv
src/slp_if.sv
src/slp_parse.sv
src/show_line_parser.sv
tb/show_line_parser_checker.sv
tb/show_line_parser_tb.sv
